// ===== rtl/ssf_pkg.sv =====
// Shared widths, defaults and item codes for the state-space filter step core.
package ssf_pkg;

	localparam int MAX_ORDER_DEF      = 4;
	localparam int COEF_FRAC_BITS_DEF = 14;

	localparam int ACTION_W    = 2;
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int COEF_IDX_W  = 5;
	localparam int STATE_W     = 32;
	localparam int ORDER_W     = 3;
	localparam int FILTERED_W  = 16;

	typedef enum logic [ACTION_W-1:0] {
		ACT_FILTER = 2'd0,
		ACT_COEF   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

endpackage

// ===== rtl/ssf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module ssf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 25,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/state_space_filter_step_core.sv =====
// Single-input single-output discrete state-space filter step with one shared MAC.
//
// Items arrive on the item channel (valid/ready). A filter item (action 0)
// produces one beat on the result channel: filtered = H.x + J.u, saturated to
// 16 bits, and the state moves to x = Phi.x + Gamma.u. A coefficient item
// (action 1) writes one entry of the [[Phi Gamma][H J]] store, a clear item
// (action 2) zeroes the state; neither gives a beat.
// cfg_we/cfg_wdata set the order in use and zero the state.
// Timing: with n = min(order, MAX_ORDER), a filter item walks (n+1)^2
// coefficients, one multiply-accumulate per cycle, through a four-stage
// pipeline (memory read, multiply, accumulate, round/saturate). The result
// beat is registered once the pipeline drains and the output register is free,
// and the core takes new items from that same cycle on. The state sits in two
// memory banks: new state goes to the idle bank, which becomes current at the
// end of the item.
// Reset restores the coefficient store to zero with J = 1.0 and the state to
// zero, at once, through per-entry valid bits. A finished result is held in
// the output register while the receiver stalls; the next item is still
// accepted and computed, and its result waits until the held beat is taken.
module state_space_filter_step_core #(
	parameter int MAX_ORDER      = ssf_pkg::MAX_ORDER_DEF,
	parameter int COEF_FRAC_BITS = ssf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ssf_pkg::ORDER_W-1:0]          cfg_wdata,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic [ssf_pkg::ACTION_W-1:0]         action,
	input  logic signed [ssf_pkg::SAMPLE_W-1:0]  sample,
	input  logic [ssf_pkg::COEF_IDX_W-1:0]       coef_index,
	input  logic signed [ssf_pkg::COEF_W-1:0]    coef_value,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [ssf_pkg::FILTERED_W-1:0] filtered,
	output logic                                 saturated
);

	import ssf_pkg::*;

	localparam int STRIDE  = MAX_ORDER + 1;
	localparam int DEPTH   = STRIDE * STRIDE;
	localparam int J_INDEX = DEPTH - 1;
	localparam int CA_W    = $clog2(DEPTH);
	localparam int SDEPTH  = 2 * MAX_ORDER;
	localparam int SA_W    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int IDX_W   = $clog2(MAX_ORDER + 1);
	localparam int F       = COEF_FRAC_BITS;
	localparam int PROD_W  = COEF_W + STATE_W;
	localparam int UTERM_W = 2 * SAMPLE_W + F;
	localparam int ACC_W   = ((UTERM_W > PROD_W) ? UTERM_W : PROD_W) + $clog2(MAX_ORDER + 1);
	localparam int RND_W   = ACC_W + 1;

	localparam logic signed [COEF_W-1:0] J_RST =
		(F >= COEF_W - 1) ? {1'b0, {(COEF_W-1){1'b1}}} : COEF_W'(1 << F);

	localparam logic signed [RND_W-1:0] HALF_OUT = RND_W'(1) << (2 * F - 1);
	localparam logic signed [RND_W-1:0] HALF_ST  = RND_W'(1) << (F - 1);
	localparam logic signed [RND_W-1:0] Y_MAX = (RND_W'(1) << (FILTERED_W - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] Y_MIN = -Y_MAX - RND_W'(1);
	localparam logic signed [RND_W-1:0] X_MAX = (RND_W'(1) << (STATE_W - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] X_MIN = -X_MAX - RND_W'(1);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDER);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} fsm_t;

	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic             orow;
		logic [IDX_W-1:0] row;
	} tag_t;

	fsm_t                       st_q;
	logic [ORDER_W-1:0]         order_q;
	logic [IDX_W-1:0]           n_q;
	logic [IDX_W-1:0]           row_q;
	logic [IDX_W-1:0]           col_q;
	logic signed [SAMPLE_W-1:0] u_q;
	logic                       bank_q;
	logic                       sat_q;
	logic [DEPTH-1:0]           cv_q;
	logic [SDEPTH-1:0]          sv_q;
	logic signed [FILTERED_W-1:0] y_q;

	logic                         out_vld_q;
	logic signed [FILTERED_W-1:0] out_y_q;
	logic                         out_sat_q;

	tag_t tag_s1, tag_s2, tag_s3;
	logic                      cv_s1, cj_s1, sv_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   sum_s3;

	logic accept, do_filter, do_coef, do_clear;
	logic ucol, orow, last_term, last_row, issue, pipe_empty, finish;
	tag_t tag_issue;

	logic              cram_we;
	logic [CA_W-1:0]   cram_waddr, cram_raddr;
	logic [COEF_W-1:0] cram_rdata;
	logic              sram_we;
	logic [SA_W-1:0]   sram_waddr, sram_raddr;
	logic [STATE_W-1:0] sram_wdata, sram_rdata;
	logic [SA_W-1:0]   rbase, wbase;

	logic signed [COEF_W-1:0]  coef_rd;
	logic signed [STATE_W-1:0] mul_b;
	logic signed [ACC_W-1:0]   term, acc_nx;
	logic signed [RND_W-1:0]   rnd, ysh, xsh;
	logic y_hi, y_lo, x_hi, x_lo, sat_now;
	logic signed [FILTERED_W-1:0] y_sat;
	logic signed [STATE_W-1:0]    x_sat;

	// ---------------------------------------------------------------- intake
	assign item_ready = (st_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign do_filter  = accept && (action == ACT_FILTER);
	assign do_coef    = accept && (action == ACT_COEF);
	assign do_clear   = accept && (action == ACT_CLEAR);

	// ---------------------------------------------------------------- issue
	assign ucol      = (col_q == LAST_IDX);
	assign orow      = (row_q == LAST_IDX);
	assign last_term = ucol ? (n_q == '0) : (col_q == n_q - IDX_W'(1));
	assign last_row  = orow ? (n_q == '0) : (row_q == n_q - IDX_W'(1));
	assign issue     = (st_q == ST_RUN);

	always_comb begin
		tag_issue       = '0;
		tag_issue.vld   = issue;
		tag_issue.first = ucol;
		tag_issue.last  = last_term;
		tag_issue.orow  = orow;
		tag_issue.row   = row_q;
	end

	assign pipe_empty = !tag_s1.vld && !tag_s2.vld && !tag_s3.vld;
	assign finish     = (st_q == ST_DRAIN) && pipe_empty && (!out_vld_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			order_q <= '0;
			bank_q  <= 1'b0;
			row_q   <= LAST_IDX;
			col_q   <= LAST_IDX;
			n_q     <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			case (st_q)
				ST_IDLE: begin
					if (do_filter) begin
						n_q   <= (32'(order_q) > MAX_ORDER) ? LAST_IDX : IDX_W'(order_q);
						row_q <= LAST_IDX;
						col_q <= LAST_IDX;
						st_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_term) begin
						col_q <= LAST_IDX;
						if (last_row) begin
							st_q <= ST_DRAIN;
						end else begin
							row_q <= orow ? '0 : row_q + IDX_W'(1);
						end
					end else begin
						col_q <= ucol ? '0 : col_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						bank_q <= ~bank_q;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_filter) begin
			u_q <= sample;
		end
	end

	// ---------------------------------------------------------------- memories
	assign cram_we    = do_coef && (32'(coef_index) < DEPTH);
	assign cram_waddr = CA_W'(coef_index);
	assign cram_raddr = CA_W'(row_q) * CA_W'(STRIDE) + CA_W'(col_q);

	assign rbase      = bank_q ? SA_W'(MAX_ORDER) : '0;
	assign wbase      = bank_q ? '0 : SA_W'(MAX_ORDER);
	assign sram_raddr = rbase + (ucol ? '0 : SA_W'(col_q));

	ssf_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (cram_we),
		.waddr (cram_waddr),
		.wdata (coef_value),
		.raddr (cram_raddr),
		.rdata (cram_rdata)
	);

	ssf_ram #(.WIDTH(STATE_W), .DEPTH(SDEPTH)) u_state_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (sram_wdata),
		.raddr (sram_raddr),
		.rdata (sram_rdata)
	);

	// entries never written read as their reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= '0;
			sv_q <= '0;
		end else begin
			if (cram_we) begin
				cv_q[cram_waddr] <= 1'b1;
			end
			if (cfg_we || do_clear) begin
				sv_q <= '0;
			end else if (sram_we) begin
				sv_q[sram_waddr] <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_issue;
			tag_s2 <= tag_s1;
			tag_s3 <= '{vld: tag_s2.vld && tag_s2.last, first: tag_s2.first,
				last: tag_s2.last, orow: tag_s2.orow, row: tag_s2.row};
		end
	end

	always_ff @(posedge clk) begin
		cv_s1 <= cv_q[cram_raddr];
		cj_s1 <= (cram_raddr == CA_W'(J_INDEX));
		sv_s1 <= sv_q[sram_raddr];
	end

	assign coef_rd = cv_s1 ? cram_rdata : (cj_s1 ? J_RST : '0);
	assign mul_b   = tag_s1.first ? STATE_W'(u_q) : (sv_s1 ? sram_rdata : '0);

	always_ff @(posedge clk) begin
		prod_s2 <= coef_rd * mul_b;
	end

	// input term carries an extra 2^F so both kinds of term share one scale
	assign term   = tag_s2.first ? (ACC_W'(prod_s2) <<< F) : ACC_W'(prod_s2);
	assign acc_nx = (tag_s2.first ? '0 : acc_q) + term;

	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			acc_q <= acc_nx;
			if (tag_s2.last) begin
				sum_s3 <= acc_nx;
			end
		end
	end

	// round half up, then saturate
	assign rnd  = RND_W'(sum_s3) + (tag_s3.orow ? HALF_OUT : HALF_ST);
	assign ysh  = rnd >>> (2 * F);
	assign xsh  = rnd >>> F;
	assign y_hi = (ysh > Y_MAX);
	assign y_lo = (ysh < Y_MIN);
	assign x_hi = (xsh > X_MAX);
	assign x_lo = (xsh < X_MIN);
	assign y_sat = y_hi ? FILTERED_W'(Y_MAX) : (y_lo ? FILTERED_W'(Y_MIN) : FILTERED_W'(ysh));
	assign x_sat = x_hi ? STATE_W'(X_MAX) : (x_lo ? STATE_W'(X_MIN) : STATE_W'(xsh));
	assign sat_now = tag_s3.orow ? (y_hi || y_lo) : (x_hi || x_lo);

	assign sram_we    = tag_s3.vld && !tag_s3.orow;
	assign sram_waddr = wbase + SA_W'(tag_s3.row);
	assign sram_wdata = x_sat;

	always_ff @(posedge clk) begin
		if (tag_s3.vld && tag_s3.orow) begin
			y_q <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (do_filter) begin
			sat_q <= 1'b0;
		end else if (tag_s3.vld && sat_now) begin
			sat_q <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (result_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_y_q   <= y_q;
			out_sat_q <= sat_q;
		end
	end

	assign result_valid = out_vld_q;
	assign filtered     = out_y_q;
	assign saturated    = out_sat_q;

	// ---------------------------------------------------------------- checks
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> pipe_empty)
		else $error("pipeline busy while idle");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st_q == ST_DRAIN))
		else $error("result raised outside drain");

	a_state_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sram_we |-> ((st_q == ST_RUN) || (st_q == ST_DRAIN)))
		else $error("state write while idle");

	a_bank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |=> $stable(bank_q))
		else $error("bank flipped during an item");

endmodule
